/* rtl/smm_pkg.sv */
// ---------------------------------------------------------------------------
// smm_pkg - shared types and constants of the small matrix multiply unit
// Dimensions, command encoding and the decoded command that the front end
// queues for the back end.
// ---------------------------------------------------------------------------
package smm_pkg;

  localparam int MAX_DIM   = 4;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W     = 64 + $clog2(MAX_DIM) + 1;

  localparam int OP_W      = 2;
  localparam int OUT_IDX_W = 2;
  localparam int DATA_W    = 32;
  localparam int SCALE_W   = 16;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [CFG_W-1:0]  CFG_DIM_RST = CFG_W'(3);
  localparam logic [DATA_W-1:0] ONE_Q16     = 32'h0001_0000;
  localparam int                FRAC_W      = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MUL    = 2'd2,
    OP_SCALE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_MUL,
    CMD_MIS,
    CMD_SCALE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic [DIM_W-1:0]           rows;
    logic [DIM_W-1:0]           cols;
    logic [DIM_W-1:0]           inner;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic [DATA_W-1:0]          value;
    logic signed [SCALE_W-1:0]  scale;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

/* rtl/smm_front.sv */
// ---------------------------------------------------------------------------
// smm_front - command decode and dimension registers
// Holds the four dimension registers, checks load indexes and inner
// dimensions, and turns each input transaction into a queued command.
// ---------------------------------------------------------------------------
module smm_front import smm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic [OUT_IDX_W-1:0]       row_index_i,
  input  logic [OUT_IDX_W-1:0]       col_index_i,
  input  logic signed [DATA_W-1:0]   element_value_i,
  input  logic signed [SCALE_W-1:0]  scale_factor_i,
  output logic                       push_o,
  output cmd_t                       cmd_o,
  input  logic                       full_i
);

  logic [CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic             idx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= CFG_DIM_RST;
      a_cols_q <= CFG_DIM_RST;
      b_rows_q <= CFG_DIM_RST;
      b_cols_q <= CFG_DIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_A_ROWS: a_rows_q <= cfg_wdata_i;
        CFG_A_COLS: a_cols_q <= cfg_wdata_i;
        CFG_B_ROWS: b_rows_q <= cfg_wdata_i;
        CFG_B_COLS: b_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ar = clamp_dim(a_rows_q);
  assign ac = clamp_dim(a_cols_q);
  assign br = clamp_dim(b_rows_q);
  assign bc = clamp_dim(b_cols_q);

  assign idx_ok = (int'(row_index_i) < MAX_DIM) && (int'(col_index_i) < MAX_DIM);

  always_comb begin
    cmd_o       = '0;
    cmd_o.row   = IDX_W'(row_index_i);
    cmd_o.col   = IDX_W'(col_index_i);
    cmd_o.value = element_value_i;
    cmd_o.scale = scale_factor_i;
    cmd_o.rows  = DIM_W'(1);
    cmd_o.cols  = DIM_W'(1);
    cmd_o.inner = DIM_W'(1);
    case (op_e'(op_i))
      OP_LOAD_A: cmd_o.kind = idx_ok ? CMD_LOAD_A : CMD_NOP;
      OP_LOAD_B: cmd_o.kind = idx_ok ? CMD_LOAD_B : CMD_NOP;
      OP_MUL: begin
        if (ac != br) begin
          cmd_o.kind = CMD_MIS;
        end else begin
          cmd_o.kind  = CMD_MUL;
          cmd_o.rows  = ar;
          cmd_o.cols  = bc;
          cmd_o.inner = ac;
        end
      end
      OP_SCALE: begin
        cmd_o.kind = CMD_SCALE;
        cmd_o.rows = ar;
        cmd_o.cols = ac;
      end
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

/* rtl/smm_queue.sv */
// ---------------------------------------------------------------------------
// smm_queue - command queue between decode and execution
// Small FIFO of decoded commands so that decode and execution stall apart.
// ---------------------------------------------------------------------------
module smm_queue import smm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output cmd_t  cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/smm_back.sv */
// ---------------------------------------------------------------------------
// smm_back - matrix stores and execution pipeline
// Executes queued commands: loads write the A/B stores, multiply and scale
// walk the result elements through one shared multiplier and accumulator,
// then round products, saturate and hold the element in the output register.
// ---------------------------------------------------------------------------
module smm_back import smm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  cmd_t                       q_cmd_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [OUT_IDX_W-1:0]       out_row_o,
  output logic [OUT_IDX_W-1:0]       out_col_o,
  output logic signed [DATA_W-1:0]   out_value_o,
  output logic                       last_o,
  output logic                       mismatch_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic                       vld;
    logic                       first;
    logic                       lastk;
    logic                       lastout;
    logic                       mis;
    logic                       scl;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic signed [SCALE_W-1:0]  scale;
  } tok_t;

  localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(32'sh8000_0000);
  localparam logic signed [ACC_W-1:0] RND_C   = ACC_W'(1) <<< (FRAC_W - 1);

  state_e            state_q;
  cmd_kind_e         kind_q;
  logic [DIM_W-1:0]  rows_q, cols_q, inner_q;
  logic [IDX_W-1:0]  i_q, j_q, k_q;
  logic signed [SCALE_W-1:0] scale_q;

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];

  logic                     en, issue, lk, lj, li;
  logic [ADDR_W-1:0]        a_raddr, b_raddr, waddr;
  logic signed [DATA_W-1:0] a_rd_q, b_rd_q, opb;
  logic signed [63:0]       prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q, rsum, shv;
  tok_t                     tok, s1_q, s2_q, s3_q;
  logic signed [DATA_W-1:0] res_val;

  // whole pipeline advances only when the output register can take a result
  assign en    = !out_valid_o || out_ready_i;
  assign issue = (state_q == ST_RUN) && en;

  assign lk = (DIM_W'(k_q) == inner_q - DIM_W'(1));
  assign lj = (DIM_W'(j_q) == cols_q - DIM_W'(1));
  assign li = (DIM_W'(i_q) == rows_q - DIM_W'(1));

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign waddr   = mem_addr(q_cmd_i.row, q_cmd_i.col);
  assign a_raddr = mem_addr(i_q, (kind_q == CMD_SCALE) ? j_q : k_q);
  assign b_raddr = mem_addr(k_q, j_q);

  always_comb begin
    tok         = '0;
    tok.vld     = issue;
    tok.first   = (k_q == '0);
    tok.lastk   = lk;
    tok.lastout = lk && lj && li;
    tok.mis     = (kind_q == CMD_MIS);
    tok.scl     = (kind_q == CMD_SCALE);
    tok.row     = i_q;
    tok.col     = j_q;
    tok.scale   = scale_q;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= CMD_NOP;
      rows_q  <= DIM_W'(1);
      cols_q  <= DIM_W'(1);
      inner_q <= DIM_W'(1);
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      scale_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            kind_q  <= q_cmd_i.kind;
            rows_q  <= q_cmd_i.rows;
            cols_q  <= q_cmd_i.cols;
            inner_q <= q_cmd_i.inner;
            scale_q <= q_cmd_i.scale;
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            if (q_cmd_i.kind inside {CMD_MUL, CMD_MIS, CMD_SCALE}) begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (!lk) begin
              k_q <= k_q + IDX_W'(1);
            end else begin
              k_q <= '0;
              if (!lj) begin
                j_q <= j_q + IDX_W'(1);
              end else begin
                j_q <= '0;
                if (li) begin
                  state_q <= ST_IDLE;
                end else begin
                  i_q <= i_q + IDX_W'(1);
                end
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // matrix stores, registered read
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cmd_i.kind == CMD_LOAD_A) begin
      a_mem[waddr] <= q_cmd_i.value;
    end
    if (issue) begin
      a_rd_q <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cmd_i.kind == CMD_LOAD_B) begin
      b_mem[waddr] <= q_cmd_i.value;
    end
    if (issue) begin
      b_rd_q <= b_mem[b_raddr];
    end
  end

  assign opb    = s1_q.scl ? {{(DATA_W-SCALE_W){s1_q.scale[SCALE_W-1]}}, s1_q.scale}
                           : b_rd_q;
  assign prod_d = a_rd_q * opb;

  always_ff @(posedge clk_i) begin
    if (en && s1_q.vld) begin
      prod_q <= prod_d;
    end
    if (en && s2_q.vld) begin
      acc_q <= s2_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (en) begin
      s1_q <= tok;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // round half up for products, then saturate to Q16.16
  assign rsum = acc_q + RND_C;
  assign shv  = s3_q.scl ? acc_q : (rsum >>> FRAC_W);

  always_comb begin
    if (s3_q.mis) begin
      res_val = ONE_Q16;
    end else if (shv > SAT_HI) begin
      res_val = SAT_HI[DATA_W-1:0];
    end else if (shv < SAT_LO) begin
      res_val = SAT_LO[DATA_W-1:0];
    end else begin
      res_val = shv[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= s3_q.vld && s3_q.lastk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s3_q.vld && s3_q.lastk) begin
      out_row_o   <= OUT_IDX_W'(s3_q.row);
      out_col_o   <= OUT_IDX_W'(s3_q.col);
      out_value_o <= res_val;
      last_o      <= s3_q.lastout;
      mismatch_o  <= s3_q.mis;
    end
  end

endmodule

/* rtl/small_matrix_multiply_scale_unit.sv */
// ---------------------------------------------------------------------------
// small_matrix_multiply_scale_unit - small fixed-point matrix multiply/scale
// Top level: decode front end, command queue and execution back end.
// ---------------------------------------------------------------------------
// Transactions are decoded and pushed into a 4-entry command queue at one per
// cycle while the queue has room. The back end takes one command at a time:
// a load only writes its store; a multiply issues one product per cycle
// (rows x cols x inner) through the single 32x32 multiplier, then through
// the product and accumulate registers to the output register; a scale
// issues one element of A per cycle the same way, and a dimension mismatch
// returns its single 1.0 element the same way. Issue holds while the output
// register stalls, which it does only while a result is held and not taken.
// A 4x4 by 4x4 multiply streams 16 results. Stores are not cleared at reset.
module small_matrix_multiply_scale_unit import smm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic [OUT_IDX_W-1:0]       row_index_i,
  input  logic [OUT_IDX_W-1:0]       col_index_i,
  input  logic signed [DATA_W-1:0]   element_value_i,
  input  logic signed [SCALE_W-1:0]  scale_factor_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [OUT_IDX_W-1:0]       out_row_o,
  output logic [OUT_IDX_W-1:0]       out_col_o,
  output logic signed [DATA_W-1:0]   out_value_o,
  output logic                       last_o,
  output logic                       mismatch_o
);

  logic push, full, q_valid, q_pop;
  cmd_t push_cmd, q_cmd;

  smm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .scale_factor_i  (scale_factor_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  smm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  smm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .last_o      (last_o),
    .mismatch_o  (mismatch_o)
  );

endmodule

/* rtl/smm_checker.sv */
// ---------------------------------------------------------------------------
// smm_checker - port-level checks of the matrix unit
// Watches the result channel of the top level; attached by bind.
// ---------------------------------------------------------------------------
module smm_checker import smm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [OUT_IDX_W-1:0]       out_row_i,
  input  logic [OUT_IDX_W-1:0]       out_col_i,
  input  logic signed [DATA_W-1:0]   out_value_i,
  input  logic                       last_i,
  input  logic                       mismatch_i
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
      $stable(out_row_i) && $stable(out_col_i) && $stable(last_i) && $stable(mismatch_i))
    else $error("result changed while stalled");

  // mismatch result is the lone 1.0 element at (0,0)
  a_mis_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mismatch_i |-> last_i && out_row_i == '0 && out_col_i == '0 &&
      out_value_i == ONE_Q16)
    else $error("malformed mismatch result");

  // a run that is not finished cannot be followed by a mismatch result
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> !(out_valid_i && mismatch_i))
    else $error("mismatch result inside a run");

  // elements after the first of a run never return to (0,0) before its end
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      !(out_valid_i && out_row_i == '0 && out_col_i == '0))
    else $error("run restarted before its last element");

endmodule

bind small_matrix_multiply_scale_unit smm_checker u_smm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_row_i   (out_row_o),
  .out_col_i   (out_col_o),
  .out_value_i (out_value_o),
  .last_i      (last_o),
  .mismatch_i  (mismatch_o)
);
